### hdl/ule_pkg.sv
// package: field widths, codes and transfer types for the unordered list engine
`timescale 1ns / 1ps
`default_nettype none
package ule_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int OP_W      = 2;
  localparam int VALUE_W   = 32;
  localparam int INDEX_W   = 8;
  localparam int STATUS_W  = 3;
  localparam int FOUND_W   = 8;
  localparam int ECOUNT_W  = 9;
  localparam int CAP_W     = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    op_t                       operation;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic [FOUND_W-1:0]        found_index;
    logic signed [VALUE_W-1:0] read_value;
    logic [ECOUNT_W-1:0]       entry_count;
  } out_item_t;

endpackage
`default_nettype wire

### hdl/ule_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module ule_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/ule_core.sv
// sequencer for append, delete, search and read that walks the entry store for search and delete
`timescale 1ns / 1ps
`default_nettype none
module ule_core (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire ule_pkg::in_item_t        item,
  input  wire logic [ule_pkg::CNT_W-1:0] cap_eff,
  output logic                          idle,
  output logic                          res_valid,
  input  wire logic                     res_take,
  output ule_pkg::out_item_t            res
);
  import ule_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_READ  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                    state, state_next;
  logic [CNT_W-1:0]          count, count_next;
  logic [CNT_W-1:0]          ptr, ptr_next;
  logic [CNT_W-1:0]          cmp_idx, cmp_idx_next;
  logic                      pend, pend_next;
  logic signed [VALUE_W-1:0] key, key_next;
  status_t                   rstat, rstat_next;
  logic [FOUND_W-1:0]        rfound, rfound_next;
  logic [VALUE_W-1:0]        rvalue, rvalue_next;

  logic                      we;
  logic [ADDR_W-1:0]         waddr;
  logic [VALUE_W-1:0]        wdata;
  logic [ADDR_W-1:0]         raddr;
  logic [VALUE_W-1:0]        rdata;
  logic [CNT_W-1:0]          wpos;
  logic                      idx_bad;

  ule_ram #(
    .DEPTH(MAX_ENTRIES),
    .WIDTH(VALUE_W)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign idx_bad   = (32'(item.index) >= 32'(count));
  assign wpos      = cmp_idx - CNT_W'(1);

  assign res.status      = rstat;
  assign res.found_index = rfound;
  assign res.read_value  = rvalue;
  assign res.entry_count = ECOUNT_W'(count);

  always_comb begin
    state_next   = state;
    count_next   = count;
    ptr_next     = ptr;
    cmp_idx_next = cmp_idx;
    pend_next    = pend;
    key_next     = key;
    rstat_next   = rstat;
    rfound_next  = rfound;
    rvalue_next  = rvalue;
    we           = 1'b0;
    waddr        = wpos[ADDR_W-1:0];
    wdata        = rdata;
    raddr        = ptr[ADDR_W-1:0];
    case (state)
      S_IDLE: begin
        if (start) begin
          key_next    = item.value;
          rstat_next  = ST_OK;
          rfound_next = '0;
          rvalue_next = '0;
          state_next  = S_DONE;
          if (item.operation == OP_APPEND) begin
            if (count >= cap_eff) begin
              rstat_next = ST_FULL;
            end else begin
              we         = 1'b1;
              waddr      = count[ADDR_W-1:0];
              wdata      = item.value;
              count_next = count + CNT_W'(1);
            end
          end else if (count == '0) begin
            rstat_next = ST_EMPTY;
          end else if (item.operation == OP_SEARCH) begin
            ptr_next   = '0;
            pend_next  = 1'b0;
            rstat_next = ST_NOT_FOUND;
            state_next = S_SCAN;
          end else if (idx_bad) begin
            rstat_next = ST_BAD_INDEX;
          end else if (item.operation == OP_DELETE) begin
            ptr_next   = CNT_W'(item.index) + CNT_W'(1);
            pend_next  = 1'b0;
            state_next = S_SHIFT;
          end else begin
            raddr      = item.index[ADDR_W-1:0];
            state_next = S_READ;
          end
        end
      end
      S_SCAN: begin
        if (pend && (rdata == key)) begin
          rstat_next  = ST_OK;
          rfound_next = FOUND_W'(cmp_idx);
          state_next  = S_DONE;
        end else if (ptr == count) begin
          state_next = S_DONE;
        end else begin
          cmp_idx_next = ptr;
          ptr_next     = ptr + CNT_W'(1);
          pend_next    = 1'b1;
        end
      end
      S_SHIFT: begin
        we = pend;
        if (ptr == count) begin
          pend_next  = 1'b0;
          count_next = count - CNT_W'(1);
          state_next = S_DONE;
        end else begin
          cmp_idx_next = ptr;
          ptr_next     = ptr + CNT_W'(1);
          pend_next    = 1'b1;
        end
      end
      S_READ: begin
        rvalue_next = rdata;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    cmp_idx <= cmp_idx_next;
    key     <= key_next;
    rstat   <= rstat_next;
    rfound  <= rfound_next;
    rvalue  <= rvalue_next;
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above store depth");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_SHIFT) |-> ptr <= count)
    else $error("walk pointer past live entries");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_READ || state == S_DONE) |=> count == $past(count))
    else $error("entry count changed outside append or delete");

  a_write_when: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_IDLE || state == S_SHIFT))
    else $error("store write outside append or delete");

endmodule
`default_nettype wire

### hdl/unordered_list_engine.sv
// top level: capacity register, command intake and result output register
// append, full, empty and bad index go straight to the result; read passes through
// the read state; search stops at the first match; delete shifts later entries down
// one command at a time: the store's single read port walks one entry per cycle,
// so the next command is taken only after the result has left the core
// a new command is taken while the previous result waits in the output register
// reset: entry count 0, capacity 256, store contents left as they are
`timescale 1ns / 1ps
`default_nettype none
module unordered_list_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire ule_pkg::in_item_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output ule_pkg::out_item_t               out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ule_pkg::CAP_W-1:0]   cfg_data
);
  import ule_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] cap_eff;
  logic             core_idle;
  logic             res_valid;
  logic             res_take;
  out_item_t        res;

  assign cfg_ready = 1'b1;
  assign in_ready  = core_idle;
  assign res_take  = !out_valid || out_ready;

  always_comb begin
    if (32'(capacity) > 32'(MAX_ENTRIES)) begin
      cap_eff = CNT_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  ule_core u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (in_valid && in_ready),
    .item     (in_data),
    .cap_eff  (cap_eff),
    .idle     (core_idle),
    .res_valid(res_valid),
    .res_take (res_take),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

### dv/tb_top.sv
// testbench: list commands and capacity writes, results checked against script or predictor
`timescale 1ns / 1ps
module tb_top;
  import ule_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 300;
  localparam int LONG_HOLD_CYCLES = 120;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [CAP_W-1:0]          cap;
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
    logic                      fixed_exp;
    out_item_t                 fixed_result;
  } script_row_t;

  typedef struct packed {
    logic [CAP_W-1:0] cap;
    logic [6:0]       tx_idle_pct;
    logic [6:0]       rx_stall_pct;
    logic [9:0]       n_items;
    logic             fill;
    logic             long_hold;
  } traffic_plan_t;

  localparam out_item_t NO_EXP = '0;
  localparam int N_SCRIPT = 29;
  localparam script_row_t SCRIPT [N_SCRIPT] = '{
    '{ROW_CFG,  9'd4, OP_APPEND, 32'sd0, 8'd0, 1'b0, NO_EXP},
    '{ROW_ITEM, 9'd0, OP_DELETE, 32'sd0, 8'd0, 1'b1, '{ST_EMPTY, 8'd0, 32'sd0, 9'd0}},
    '{ROW_ITEM, 9'd0, OP_SEARCH, 32'sd5, 8'd0, 1'b1, '{ST_EMPTY, 8'd0, 32'sd0, 9'd0}},
    '{ROW_ITEM, 9'd0, OP_READ, 32'sd0, 8'd0, 1'b1, '{ST_EMPTY, 8'd0, 32'sd0, 9'd0}},
    '{ROW_ITEM, 9'd0, OP_APPEND, 32'sh7FFF_FFFF, 8'd0, 1'b1,
      '{ST_OK, 8'd0, 32'sd0, 9'd1}},
    '{ROW_ITEM, 9'd0, OP_APPEND, 32'sh8000_0000, 8'd0, 1'b1,
      '{ST_OK, 8'd0, 32'sd0, 9'd2}},
    '{ROW_ITEM, 9'd0, OP_APPEND, 32'sd0, 8'd255, 1'b1, '{ST_OK, 8'd0, 32'sd0, 9'd3}},
    '{ROW_ITEM, 9'd0, OP_APPEND, 32'shFFFF_FFFF, 8'd0, 1'b1,
      '{ST_OK, 8'd0, 32'sd0, 9'd4}},
    '{ROW_ITEM, 9'd0, OP_APPEND, 32'sd1, 8'd0, 1'b1, '{ST_FULL, 8'd0, 32'sd0, 9'd4}},
    '{ROW_ITEM, 9'd0, OP_READ, 32'sd0, 8'd0, 1'b1,
      '{ST_OK, 8'd0, 32'sh7FFF_FFFF, 9'd4}},
    '{ROW_ITEM, 9'd0, OP_READ, 32'sd0, 8'd1, 1'b1,
      '{ST_OK, 8'd0, 32'sh8000_0000, 9'd4}},
    '{ROW_ITEM, 9'd0, OP_READ, 32'sd0, 8'd4, 1'b1, '{ST_BAD_INDEX, 8'd0, 32'sd0, 9'd4}},
    '{ROW_ITEM, 9'd0, OP_READ, 32'sd0, 8'd255, 1'b1, '{ST_BAD_INDEX, 8'd0, 32'sd0, 9'd4}},
    '{ROW_ITEM, 9'd0, OP_SEARCH, 32'shFFFF_FFFF, 8'd0, 1'b1,
      '{ST_OK, 8'd3, 32'sd0, 9'd4}},
    '{ROW_ITEM, 9'd0, OP_SEARCH, 32'sd12345, 8'd0, 1'b1,
      '{ST_NOT_FOUND, 8'd0, 32'sd0, 9'd4}},
    '{ROW_ITEM, 9'd0, OP_DELETE, 32'sd0, 8'd255, 1'b1, '{ST_BAD_INDEX, 8'd0, 32'sd0, 9'd4}},
    '{ROW_ITEM, 9'd0, OP_DELETE, 32'sd0, 8'd1, 1'b1, '{ST_OK, 8'd0, 32'sd0, 9'd3}},
    '{ROW_ITEM, 9'd0, OP_READ, 32'sd0, 8'd1, 1'b0, NO_EXP},
    '{ROW_CFG,  9'd0, OP_APPEND, 32'sd0, 8'd0, 1'b0, NO_EXP},
    '{ROW_ITEM, 9'd0, OP_APPEND, 32'sd9, 8'd0, 1'b1, '{ST_FULL, 8'd0, 32'sd0, 9'd3}},
    '{ROW_CFG,  9'd2, OP_APPEND, 32'sd0, 8'd0, 1'b0, NO_EXP},
    '{ROW_ITEM, 9'd0, OP_APPEND, 32'sd9, 8'd0, 1'b1, '{ST_FULL, 8'd0, 32'sd0, 9'd3}},
    '{ROW_CFG,  9'd511, OP_APPEND, 32'sd0, 8'd0, 1'b0, NO_EXP},
    '{ROW_ITEM, 9'd0, OP_APPEND, 32'shFFFF_FFFF, 8'd0, 1'b0, NO_EXP},
    '{ROW_ITEM, 9'd0, OP_SEARCH, 32'shFFFF_FFFF, 8'd0, 1'b0, NO_EXP},
    '{ROW_ITEM, 9'd0, OP_DELETE, 32'sd0, 8'd3, 1'b0, NO_EXP},
    '{ROW_ITEM, 9'd0, OP_DELETE, 32'sd0, 8'd0, 1'b0, NO_EXP},
    '{ROW_ITEM, 9'd0, OP_SEARCH, 32'sd0, 8'd0, 1'b0, NO_EXP},
    '{ROW_ITEM, 9'd0, OP_READ, 32'sd0, 8'd0, 1'b0, NO_EXP}
  };

  localparam int N_PLAN = 6;
  localparam traffic_plan_t PLAN [N_PLAN] = '{
    '{9'd511, 7'd0, 7'd0, 10'd40, 1'b0, 1'b0},
    '{9'd0, 7'd74, 7'd0, 10'd16, 1'b0, 1'b0},
    '{9'd1, 7'd0, 7'd74, 10'd30, 1'b0, 1'b1},
    '{9'd7, 7'd33, 7'd33, 10'd40, 1'b0, 1'b0},
    '{9'd256, 7'd0, 7'd0, 10'd290, 1'b1, 1'b0},
    '{9'd3, 7'd33, 7'd33, 10'd24, 1'b0, 1'b0}
  };

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  logic signed [VALUE_W-1:0] shadow_entries [MAX_ENTRIES];
  int shadow_count = 0;
  logic [CAP_W-1:0] shadow_capacity = CAP_RESET;
  out_item_t pending_results [$];

  int fail_count = 0;
  int quiet_cycles = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit long_hold_phase = 1'b0;
  bit hold_served = 1'b0;
  int hold_left = 0;

  unordered_list_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic out_item_t apply_list_op(input in_item_t it);
    out_item_t r;
    int lim;
    int i;
    r = '0;
    r.status = ST_OK;
    lim = (int'(shadow_capacity) > MAX_ENTRIES) ? MAX_ENTRIES : int'(shadow_capacity);
    if (it.operation == OP_APPEND) begin
      if (shadow_count >= lim) begin
        r.status = ST_FULL;
      end else begin
        shadow_entries[shadow_count] = it.value;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else if (int'(it.index) >= shadow_count && it.operation != OP_SEARCH) begin
      r.status = ST_BAD_INDEX;
    end else begin
      case (it.operation)
        OP_DELETE: begin
          for (i = int'(it.index); i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i + 1];
          shadow_count--;
        end
        OP_SEARCH: begin
          r.status = ST_NOT_FOUND;
          for (i = 0; i < shadow_count && r.status != ST_OK; i++) begin
            if (shadow_entries[i] == it.value) begin
              r.status = ST_OK;
              r.found_index = i[FOUND_W-1:0];
            end
          end
        end
        default: r.read_value = shadow_entries[it.index];
      endcase
    end
    r.entry_count = shadow_count[ECOUNT_W-1:0];
    return r;
  endfunction

  // mostly in-range indexes; values drawn from the list, the signed extremes, small values or at random
  function automatic in_item_t random_item(input bit fill);
    in_item_t it;
    int roll;
    roll = $urandom_range(99);
    it.index = INDEX_W'($urandom_range(255));
    it.value = $urandom;
    if (roll < (fill ? 95 : 35)) it.operation = OP_APPEND;
    else if (roll < (fill ? 96 : 55)) it.operation = OP_DELETE;
    else if (roll < (fill ? 98 : 80)) it.operation = OP_SEARCH;
    else it.operation = OP_READ;
    if (shadow_count > 0 && $urandom_range(99) < 85)
      it.index = INDEX_W'($urandom_range(shadow_count - 1));
    case ($urandom_range(9))
      0: it.value = 32'sh7FFF_FFFF;
      1: it.value = 32'sh8000_0000;
      2: it.value = $urandom_range(3);
      3, 4, 5: begin
        if (shadow_count > 0) it.value = shadow_entries[$urandom_range(shadow_count - 1)];
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input bit use_fixed, input out_item_t fixed_r);
    out_item_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predicted = apply_list_op(it);
    pending_results.push_back(use_fixed ? fixed_r : predicted);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    shadow_capacity = cap;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (long_hold_phase && !hold_served) begin
      hold_served = 1'b1;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no pending expectation");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.found_index !== want.found_index) begin
          $error("found_index expected %0d actual %0d", want.found_index,
                 out_data.found_index);
          fail_count++;
        end
        if (out_data.read_value !== want.read_value) begin
          $error("read_value expected %0d actual %0d", want.read_value,
                 out_data.read_value);
          fail_count++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count expected %0d actual %0d", want.entry_count,
                 out_data.entry_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_item_t item;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_SCRIPT; r++) begin
      if (SCRIPT[r].kind == ROW_CFG) begin
        write_capacity(SCRIPT[r].cap);
      end else begin
        item = '{SCRIPT[r].op, SCRIPT[r].value, SCRIPT[r].index};
        send_item(item, SCRIPT[r].fixed_exp, SCRIPT[r].fixed_result);
      end
    end

    for (int p = 0; p < N_PLAN; p++) begin
      write_capacity(PLAN[p].cap);
      tx_idle_pct = int'(PLAN[p].tx_idle_pct);
      rx_stall_pct = int'(PLAN[p].rx_stall_pct);
      long_hold_phase = PLAN[p].long_hold;
      repeat (PLAN[p].n_items) send_item(random_item(PLAN[p].fill), 1'b0, NO_EXP);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/ule_pkg.sv
hdl/ule_ram.sv
hdl/ule_core.sv
hdl/unordered_list_engine.sv
dv/tb_top.sv
